// ----- hw/rtl/srge_pkg.sv -----
package srge_pkg;

  localparam int SAMPLE_BITS_DEF        = 24;
  localparam int POSITION_BITS_DEF      = 24;
  localparam int SMOOTH_EDGE_FRAMES_DEF = 32;

  // Q1.16 gain, 65536 is unity
  localparam int GAIN_W = 17;
  localparam int UNITY_GAIN_INT = 65536;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(UNITY_GAIN_INT);
  localparam int GAIN_FRAC = 16;

  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int USER_W    = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS     = 3'd0,
    MODE_SILENCE  = 3'd1,
    MODE_FADE_IN  = 3'd2,
    MODE_FADE_OUT = 3'd3,
    MODE_SMOOTH   = 3'd4
  } edit_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_START = 2'd0,
    REG_REGION_END   = 2'd1,
    REG_EDIT_MODE    = 2'd2
  } cfg_reg_e;

  // gains for the two passes through each lane multiplier
  typedef struct packed {
    logic [GAIN_W-1:0] g1;
    logic              use1;
    logic [GAIN_W-1:0] g2;
    logic              use2;
  } gain_t;

  typedef struct packed {
    logic load;
    logic step1;
    logic step2;
  } lane_ctl_t;

endpackage

// ----- hw/rtl/srge_div.sv -----
module srge_div #(
  parameter int POSITION_BITS = srge_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [POSITION_BITS-1:0]      region_start_i,
  input  logic [POSITION_BITS-1:0]      region_end_i,
  output logic                          busy_o,
  output logic [srge_pkg::GAIN_W-1:0]   quot_o
);

  // restoring division of unity by the region length, one quotient bit a cycle
  localparam int DIV_STEPS = srge_pkg::GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 2);
  localparam int IDX_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_STEPS + 1);

  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [POSITION_BITS-1:0]        len_q;
  logic [POSITION_BITS-1:0]        rem_q, rem_d;
  logic [srge_pkg::GAIN_W-1:0]     quot_q, quot_d;
  logic [POSITION_BITS:0]          rem_sh;
  logic [POSITION_BITS:0]          rem_diff;
  logic [IDX_W-1:0]                bit_idx;
  logic                            qbit;

  always_comb begin
    bit_idx  = IDX_W'(cnt_q - CNT_W'(1));
    rem_sh   = {rem_q, srge_pkg::UNITY_GAIN[bit_idx]};
    rem_diff = rem_sh - {1'b0, len_q};
    qbit     = (rem_sh >= {1'b0, len_q});
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    if (start_i) begin
      cnt_d = CNT_LOAD;
    end else if (cnt_q == CNT_LOAD) begin
      cnt_d  = cnt_q - CNT_W'(1);
      rem_d  = '0;
      quot_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      rem_d  = qbit ? rem_diff[POSITION_BITS-1:0] : rem_sh[POSITION_BITS-1:0];
      quot_d = {quot_q[srge_pkg::GAIN_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      quot_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (cnt_q == CNT_LOAD) begin
      len_q <= region_end_i - region_start_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/srge_ctrl.sv -----
module srge_ctrl #(
  parameter int POSITION_BITS      = srge_pkg::POSITION_BITS_DEF,
  parameter int SMOOTH_EDGE_FRAMES = srge_pkg::SMOOTH_EDGE_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          restart_i,
  input  logic [POSITION_BITS-1:0]      region_start_i,
  input  logic [POSITION_BITS-1:0]      region_end_i,
  input  logic [srge_pkg::MODE_W-1:0]   edit_mode_i,
  input  logic [srge_pkg::GAIN_W-1:0]   quot_i,
  output srge_pkg::gain_t               gain_o
);

  localparam int EXT_W = 11;  // room for edge lengths up to 1024
  localparam int CMP_W = POSITION_BITS + EXT_W;
  localparam int EW    = $clog2(SMOOTH_EDGE_FRAMES + 1);
  localparam logic [CMP_W-1:0] EDGE = CMP_W'(SMOOTH_EDGE_FRAMES);
  localparam logic [srge_pkg::GAIN_W-1:0] ESTEP =
    srge_pkg::GAIN_W'(srge_pkg::UNITY_GAIN_INT / SMOOTH_EDGE_FRAMES);

  logic [POSITION_BITS-1:0]      pos_q, pos;
  logic [srge_pkg::GAIN_W-1:0]   acc_q, acc_d, acc_cur;
  logic [srge_pkg::GAIN_W-1:0]   step_q, step_cur;
  logic [POSITION_BITS-1:0]      len_raw, off_raw, rem_raw;
  logic [CMP_W-1:0]              len_e, off_e, rem_e, dn_e;
  logic                          nonempty, in_region, at_start;
  logic                          long_region, in_head, in_tail;
  logic [srge_pkg::GAIN_W-1:0]   g_head, g_tail, g_acc;
  srge_pkg::edit_mode_e          mode;
  srge_pkg::gain_t               gain_d, gain_q;

  always_comb begin
    mode      = srge_pkg::edit_mode_e'(edit_mode_i);
    pos       = restart_i ? '0 : pos_q;
    nonempty  = region_end_i > region_start_i;
    in_region = nonempty && (pos >= region_start_i) && (pos < region_end_i);
    at_start  = nonempty && (pos == region_start_i);

    len_raw = region_end_i - region_start_i;
    off_raw = pos - region_start_i;
    rem_raw = region_end_i - pos;
    len_e   = {EXT_W'(0), len_raw};
    off_e   = {EXT_W'(0), off_raw};
    rem_e   = {EXT_W'(0), rem_raw};
    dn_e    = EDGE - rem_e;

    long_region = len_e >= EDGE;
    in_head     = off_e < EDGE;
    in_tail     = rem_e <= EDGE;
    g_head      = srge_pkg::GAIN_W'(off_e[EW-1:0] * ESTEP);
    g_tail      = srge_pkg::UNITY_GAIN - srge_pkg::GAIN_W'(dn_e[EW-1:0] * ESTEP);

    step_cur = at_start ? quot_i : step_q;
    if (at_start) begin
      acc_cur = (mode == srge_pkg::MODE_FADE_IN) ? '0 : srge_pkg::UNITY_GAIN;
    end else begin
      acc_cur = acc_q;
    end
    g_acc = (acc_cur > srge_pkg::UNITY_GAIN) ? srge_pkg::UNITY_GAIN : acc_cur;

    acc_d  = acc_q;
    gain_d = '0;
    if (in_region) begin
      case (mode) inside
        srge_pkg::MODE_SILENCE: begin
          gain_d.use1 = 1'b1;
        end
        srge_pkg::MODE_FADE_IN, srge_pkg::MODE_FADE_OUT: begin
          gain_d.g1   = g_acc;
          gain_d.use1 = 1'b1;
          acc_d = (mode == srge_pkg::MODE_FADE_IN) ? acc_cur + step_cur
                                                   : acc_cur - step_cur;
        end
        srge_pkg::MODE_SMOOTH: begin
          // a frame in both edges takes the head gain then the tail gain
          gain_d.g1   = g_head;
          gain_d.use1 = long_region && in_head;
          gain_d.g2   = g_tail;
          gain_d.use2 = long_region && in_tail;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      acc_q  <= '0;
      step_q <= '0;
    end else if (accept_i) begin
      pos_q  <= pos + POSITION_BITS'(1);
      acc_q  <= acc_d;
      step_q <= step_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      gain_q <= gain_d;
    end
  end

  assign gain_o = gain_q;

endmodule

// ----- hw/rtl/srge_lane.sv -----
module srge_lane #(
  parameter int SAMPLE_BITS = srge_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  srge_pkg::lane_ctl_t     ctl_i,
  input  srge_pkg::gain_t         gain_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic [SAMPLE_BITS-1:0]  sample_o
);

  localparam int PROD_W = SAMPLE_BITS + srge_pkg::GAIN_W + 1;

  logic [SAMPLE_BITS-1:0]        d_q;
  logic [srge_pkg::GAIN_W-1:0]   gsel;
  logic signed [PROD_W-1:0]      prod, shifted;
  logic [SAMPLE_BITS-1:0]        mres;

  // one multiplier, used once per pass
  always_comb begin
    gsel    = ctl_i.step2 ? gain_i.g2 : gain_i.g1;
    prod    = $signed(d_q) * $signed({1'b0, gsel});
    shifted = prod >>> srge_pkg::GAIN_FRAC;
    mres    = shifted[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      d_q <= sample_i;
    end else if (ctl_i.step1 && gain_i.use1) begin
      d_q <= mres;
    end
  end

  assign sample_o = gain_i.use2 ? mres : d_q;

endmodule

// ----- hw/rtl/stereo_region_gain_envelope_unit.sv -----
// An accepted item takes two gain passes per lane multiplier, in MUL1 and MUL2.
// MUL2 waits for a free output register; the next item is taken only in IDLE.
// A write to region_start or region_end stalls input while the
// serial divider works out the fade step, one quotient bit per cycle.
// Reset (rst_ni low, asynchronous) clears config, state, position, fade gain and step.
module stereo_region_gain_envelope_unit #(
  parameter int SAMPLE_BITS        = srge_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS      = srge_pkg::POSITION_BITS_DEF,
  parameter int SMOOTH_EDGE_FRAMES = srge_pkg::SMOOTH_EDGE_FRAMES_DEF,
  localparam int DATA_W            = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [DATA_W-1:0]               s_axis_tdata_i,  // left_sample, right_sample
  input  logic [srge_pkg::USER_W-1:0]     s_axis_tuser_i,  // restart
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [DATA_W-1:0]               m_axis_tdata_o,  // left_out, right_out
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srge_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [POSITION_BITS-1:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL1 = 3'b010,
    ST_MUL2 = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  logic [POSITION_BITS-1:0]       region_start_q, region_end_q;
  logic [srge_pkg::MODE_W-1:0]    edit_mode_q;
  logic                           cfg_we, div_start, div_busy;
  logic [srge_pkg::GAIN_W-1:0]    quot;
  logic                           accept, out_free;
  logic                           out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]         out_left_q, out_right_q;
  logic [SAMPLE_BITS-1:0]         lane_left, lane_right;
  srge_pkg::gain_t                gain;
  srge_pkg::lane_ctl_t            lane_ctl;
  srge_pkg::cfg_reg_e             cfg_idx;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_idx     = srge_pkg::cfg_reg_e'(cfg_index_i);
  assign div_start   = cfg_we && ((cfg_idx == srge_pkg::REG_REGION_START) ||
                                  (cfg_idx == srge_pkg::REG_REGION_END));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_end_q   <= '0;
      edit_mode_q    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srge_pkg::REG_REGION_START: region_start_q <= cfg_data_i;
        srge_pkg::REG_REGION_END:   region_end_q   <= cfg_data_i;
        srge_pkg::REG_EDIT_MODE:    edit_mode_q    <= cfg_data_i[srge_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srge_div #(
    .POSITION_BITS (POSITION_BITS)
  ) u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (div_start),
    .region_start_i (region_start_q),
    .region_end_i   (region_end_q),
    .busy_o         (div_busy),
    .quot_o         (quot)
  );

  // sequencing
  assign s_axis_tready_o = (state_q == ST_IDLE) && !div_busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    lane_ctl.load  = accept;
    lane_ctl.step1 = (state_q == ST_MUL1);
    lane_ctl.step2 = (state_q == ST_MUL2);
  end

  srge_ctrl #(
    .POSITION_BITS      (POSITION_BITS),
    .SMOOTH_EDGE_FRAMES (SMOOTH_EDGE_FRAMES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .restart_i      (s_axis_tuser_i[0]),
    .region_start_i (region_start_q),
    .region_end_i   (region_end_q),
    .edit_mode_i    (edit_mode_q),
    .quot_i         (quot),
    .gain_o         (gain)
  );

  srge_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .gain_i   (gain),
    .sample_i (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .sample_o (lane_left)
  );

  srge_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .gain_i   (gain),
    .sample_i (s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .sample_o (lane_right)
  );

  // merge both lanes into the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == ST_MUL2) && out_free) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_MUL2) && out_free) begin
      out_left_q  <= lane_left;
      out_right_q <= lane_right;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DATA_W'({out_right_q, out_left_q});

endmodule

// ----- hw/rtl/srge_checker.sv -----
module srge_checker #(
  parameter int SAMPLE_BITS   = srge_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_i,
  input logic                            m_tvalid_i,
  input logic                            m_tready_i,
  input logic [DATA_W-1:0]               m_tdata_i,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_i,
  input logic [srge_pkg::CFG_IDX_W-1:0]  cfg_index_i
);

  logic region_write;
  assign region_write = cfg_valid_i && cfg_ready_i &&
                        ((cfg_index_i == srge_pkg::REG_REGION_START) ||
                         (cfg_index_i == srge_pkg::REG_REGION_END));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("second item taken while one is in the lanes");

  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    region_write |=> !s_tready_i)
    else $error("input open while the fade step is being divided");

endmodule

bind stereo_region_gain_envelope_unit srge_checker #(
  .SAMPLE_BITS   (SAMPLE_BITS)
) u_srge_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .s_tvalid_i  (s_axis_tvalid_i),
  .s_tready_i  (s_axis_tready_o),
  .m_tvalid_i  (m_axis_tvalid_o),
  .m_tready_i  (m_axis_tready_i),
  .m_tdata_i   (m_axis_tdata_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o),
  .cfg_index_i (cfg_index_i)
);
